// ----- hw/rtl/digit_weighted_hash_table_macros.svh -----
// ----------------------------------------------------------------------------
// Digit weighted hash table - assertion macros
// Shared property forms for the checker.
// ----------------------------------------------------------------------------
`ifndef DIGIT_WEIGHTED_HASH_TABLE_MACROS_SVH
`define DIGIT_WEIGHTED_HASH_TABLE_MACROS_SVH

// same-cycle implication
`define DWHT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DWHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/dwht_pkg.sv -----
// ----------------------------------------------------------------------------
// dwht_pkg
// Shared widths, codes and types of the digit weighted hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package dwht_pkg;

  localparam int KEY_W        = 24;
  localparam int VALUE_W      = 32;
  localparam int STATUS_W     = 2;
  localparam int WEIGHT_W     = 3;
  localparam int WEIGHT_COUNT = 7;
  localparam int CFG_IDX_W    = 3;
  localparam int DIGIT_W      = 4;
  localparam int STEP_W       = 3;
  localparam int PROD_W       = 6;
  localparam int SUM_W        = 7;
  localparam int MUL_W        = 48;

  // x / 10 == (x * RECIP10) >> RECIP10_SHIFT for any 24-bit x
  localparam logic [KEY_W-1:0] RECIP10       = 24'hCCCCCD;
  localparam int               RECIP10_SHIFT = 27;

  localparam int BUCKETS_DEF          = 7;
  localparam int SLOTS_PER_BUCKET_DEF = 8;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic               opcode;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } item_t;

  typedef logic [WEIGHT_COUNT-1:0][WEIGHT_W-1:0] weights_t;

endpackage

`default_nettype wire

// ----- hw/rtl/digit_weighted_hash_table.sv -----
// ----------------------------------------------------------------------------
// digit_weighted_hash_table
// Bucketed key-value store hashed by weighted decimal digits of the key.
//
// Channel   Direction  Transaction on                Carries
// command   in         start && !busy                opcode, key, value
// result    out        done (one cycle)              status, result_key,
//                                                    result_value
// config    in         cfg_valid && cfg_ready        cfg_index, cfg_data
//
// Front end: accept, 7 digit steps, fold, hand-off; the hand-off waits while
// the queue is full. Back end: one slot read a cycle from the slot memory
// across the bucket, then a finish step. The front end can take a new command
// while the back end is still scanning the previous one.
// Reset clears weights to 1 and all slot valid bits at once; no clearing pass.
// done is not held: the receiver takes each result in its single cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module digit_weighted_hash_table #(
  parameter int BUCKETS          = dwht_pkg::BUCKETS_DEF,
  parameter int SLOTS_PER_BUCKET = dwht_pkg::SLOTS_PER_BUCKET_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            opcode,
  input  wire logic [dwht_pkg::KEY_W-1:0]      key,
  input  wire logic [dwht_pkg::VALUE_W-1:0]    value,
  output logic                                 done,
  output logic [dwht_pkg::STATUS_W-1:0]        status,
  output logic [dwht_pkg::KEY_W-1:0]           result_key,
  output logic [dwht_pkg::VALUE_W-1:0]         result_value,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [dwht_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dwht_pkg::WEIGHT_W-1:0]   cfg_data
);

  localparam int BW = $clog2(BUCKETS);
  localparam int QW = $bits(dwht_pkg::item_t) + BW;

  dwht_pkg::weights_t weights;
  dwht_pkg::item_t    in_item;
  logic               q_full;
  logic               q_push;
  logic [QW-1:0]      q_din;
  logic               q_empty;
  logic               q_pop;
  logic [QW-1:0]      q_dout;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      weights <= {dwht_pkg::WEIGHT_COUNT{dwht_pkg::WEIGHT_W'(1)}};
    end else if (cfg_valid && cfg_index < dwht_pkg::CFG_IDX_W'(dwht_pkg::WEIGHT_COUNT)) begin
      weights[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    in_item.opcode = opcode;
    in_item.key    = key;
    in_item.value  = value;
  end

  dwht_front #(
    .BUCKETS (BUCKETS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .weights (weights),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_din)
  );

  dwht_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  dwht_back #(
    .BUCKETS          (BUCKETS),
    .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_dout       (q_dout),
    .q_pop        (q_pop),
    .done         (done),
    .status       (status),
    .result_key   (result_key),
    .result_value (result_value)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/dwht_queue.sv -----
// ----------------------------------------------------------------------------
// dwht_queue
// Two-entry queue between the hashing front end and the bucket scanner.
// ----------------------------------------------------------------------------
`default_nettype none

module dwht_queue #(
  parameter int WIDTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  empty
);

  localparam int DEPTH = 2;

  logic [WIDTH-1:0] entry [DEPTH];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full  = (count == 2'(DEPTH));
  assign empty = (count == 2'd0);
  assign dout  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dwht_front.sv -----
// ----------------------------------------------------------------------------
// dwht_front
// Accepts a command, splits the seven low decimal digits off the key (one per
// cycle) and folds the weighted digits into a bucket index.
// ----------------------------------------------------------------------------
`default_nettype none

module dwht_front #(
  parameter int BUCKETS = dwht_pkg::BUCKETS_DEF,
  localparam int BW     = $clog2(BUCKETS),
  localparam int QW     = $bits(dwht_pkg::item_t) + BW
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire dwht_pkg::item_t   in_item,
  input  wire dwht_pkg::weights_t weights,
  input  wire logic              q_full,
  output logic                   q_push,
  output logic [QW-1:0]          q_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HASH = 2'd1;
  localparam logic [1:0] S_PUSH = 2'd2;

  logic [1:0]                        state;
  logic [dwht_pkg::STEP_W-1:0]       step;
  dwht_pkg::item_t                   item;
  logic [dwht_pkg::KEY_W-1:0]        rest;
  logic [dwht_pkg::DIGIT_W-1:0]      digit;
  logic [dwht_pkg::STEP_W-1:0]       dpos;
  logic                              digit_vld;
  logic [BW-1:0]                     acc;

  logic [dwht_pkg::MUL_W-1:0]        prod_q;
  logic [dwht_pkg::KEY_W-1:0]        quot;
  logic [dwht_pkg::KEY_W-1:0]        quot10;
  logic [dwht_pkg::KEY_W-1:0]        rem_full;
  logic [dwht_pkg::PROD_W-1:0]       wprod;
  logic [dwht_pkg::SUM_W-1:0]        sum;
  logic [BW-1:0]                     acc_next;
  logic [BW-1:0]                     mod_tab [2**dwht_pkg::SUM_W];

  for (genvar i = 0; i < 2**dwht_pkg::SUM_W; i++) begin : g_mod
    assign mod_tab[i] = BW'(i % BUCKETS);
  end

  always_comb begin
    prod_q   = dwht_pkg::MUL_W'(rest) * dwht_pkg::MUL_W'(dwht_pkg::RECIP10);
    quot     = dwht_pkg::KEY_W'(prod_q >> dwht_pkg::RECIP10_SHIFT);
    quot10   = (quot << 3) + (quot << 1);
    rem_full = rest - quot10;
    wprod    = dwht_pkg::PROD_W'(weights[dpos]) * dwht_pkg::PROD_W'(digit);
    sum      = dwht_pkg::SUM_W'(acc) + dwht_pkg::SUM_W'(wprod);
    acc_next = mod_tab[sum];
  end

  assign busy   = (state != S_IDLE);
  assign q_push = (state == S_PUSH) && !q_full;
  assign q_data = {item, acc};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      digit_vld <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          digit_vld <= 1'b0;
          if (start) begin
            state <= S_HASH;
          end
        end
        S_HASH: begin
          digit_vld <= (step != dwht_pkg::STEP_W'(dwht_pkg::WEIGHT_COUNT));
          if (step == dwht_pkg::STEP_W'(dwht_pkg::WEIGHT_COUNT) && digit_vld) begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!q_full) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          item <= in_item;
          rest <= in_item.key;
          step <= '0;
          acc  <= '0;
        end
      end
      S_HASH: begin
        if (step != dwht_pkg::STEP_W'(dwht_pkg::WEIGHT_COUNT)) begin
          digit <= rem_full[dwht_pkg::DIGIT_W-1:0];
          dpos  <= step;
          rest  <= quot;
          step  <= step + 1'b1;
        end
        if (digit_vld) begin
          acc <= acc_next;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dwht_back.sv -----
// ----------------------------------------------------------------------------
// dwht_back
// Scans the slots of one bucket, then updates, inserts or reports, one
// command at a time. Slot keys and values live in a single-port-read memory.
// ----------------------------------------------------------------------------
`default_nettype none

module dwht_back #(
  parameter int BUCKETS          = dwht_pkg::BUCKETS_DEF,
  parameter int SLOTS_PER_BUCKET = dwht_pkg::SLOTS_PER_BUCKET_DEF,
  localparam int BW              = $clog2(BUCKETS),
  localparam int QW              = $bits(dwht_pkg::item_t) + BW
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_empty,
  input  wire logic [QW-1:0]                 q_dout,
  output logic                               q_pop,
  output logic                               done,
  output logic [dwht_pkg::STATUS_W-1:0]      status,
  output logic [dwht_pkg::KEY_W-1:0]         result_key,
  output logic [dwht_pkg::VALUE_W-1:0]       result_value
);

  localparam int ENTRIES = BUCKETS * SLOTS_PER_BUCKET;
  localparam int AW      = $clog2(ENTRIES);
  localparam int SW      = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int DW      = dwht_pkg::KEY_W + dwht_pkg::VALUE_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [DW-1:0]                 slot_mem [ENTRIES];
  logic [ENTRIES-1:0]            slot_valid;

  logic [1:0]                    state;
  dwht_pkg::item_t               item;
  logic [AW-1:0]                 base;
  logic [SW-1:0]                 iss;
  logic                          cmp_vld;
  logic [AW-1:0]                 cmp_addr;
  logic [DW-1:0]                 rd_data;
  logic                          hit_found;
  logic [AW-1:0]                 hit_addr;
  logic [dwht_pkg::VALUE_W-1:0]  hit_value;
  logic                          free_found;
  logic [AW-1:0]                 free_addr;

  dwht_pkg::item_t               q_item;
  logic [BW-1:0]                 q_bucket;
  logic                          issue;
  logic [AW-1:0]                 rd_addr;
  logic [dwht_pkg::KEY_W-1:0]    rd_key;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;

  always_comb begin
    q_item   = dwht_pkg::item_t'(q_dout[QW-1:BW]);
    q_bucket = q_dout[BW-1:0];
    q_pop    = (state == S_IDLE) && !q_empty;
    issue    = (state == S_SCAN) && (iss != SW'(SLOTS_PER_BUCKET));
    rd_addr  = base + AW'(iss);
    rd_key   = rd_data[DW-1:dwht_pkg::VALUE_W];
    wr_en    = (state == S_FINISH) && (item.opcode == dwht_pkg::OP_INSERT)
               && (hit_found || free_found);
    wr_addr  = hit_found ? hit_addr : free_addr;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= {item.key, item.value};
    end
    if (issue) begin
      rd_data <= slot_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (wr_en) begin
      slot_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      cmp_vld <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          cmp_vld <= 1'b0;
          if (!q_empty) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          cmp_vld <= issue;
          if (!issue && cmp_vld) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          item       <= q_item;
          base       <= AW'(q_bucket * SLOTS_PER_BUCKET);
          iss        <= '0;
          hit_found  <= 1'b0;
          free_found <= 1'b0;
        end
      end
      S_SCAN: begin
        if (issue) begin
          iss <= iss + 1'b1;
        end
        cmp_addr <= rd_addr;
        if (cmp_vld) begin
          if (slot_valid[cmp_addr]) begin
            if (!hit_found && rd_key == item.key) begin
              hit_found <= 1'b1;
              hit_addr  <= cmp_addr;
              hit_value <= rd_data[dwht_pkg::VALUE_W-1:0];
            end
          end else if (!free_found) begin
            free_found <= 1'b1;
            free_addr  <= cmp_addr;
          end
        end
      end
      S_FINISH: begin
        if (item.opcode == dwht_pkg::OP_SEARCH) begin
          if (hit_found) begin
            status       <= dwht_pkg::ST_OK;
            result_key   <= item.key;
            result_value <= hit_value;
          end else begin
            status       <= dwht_pkg::ST_MISS;
            result_key   <= '0;
            result_value <= '0;
          end
        end else if (hit_found || free_found) begin
          status       <= dwht_pkg::ST_OK;
          result_key   <= item.key;
          result_value <= item.value;
        end else begin
          status       <= dwht_pkg::ST_FULL;
          result_key   <= '0;
          result_value <= '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dwht_checker.sv -----
// ----------------------------------------------------------------------------
// dwht_checker
// Port-level checks on the digit weighted hash table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "digit_weighted_hash_table_macros.svh"

module dwht_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          done,
  input wire logic [dwht_pkg::STATUS_W-1:0] status,
  input wire logic [dwht_pkg::KEY_W-1:0]    result_key,
  input wire logic [dwht_pkg::VALUE_W-1:0]  result_value
);

  logic payload_zero;
  logic is_miss;
  logic is_full;

  assign payload_zero = (result_key == '0) && (result_value == '0);
  assign is_miss      = done && (status == dwht_pkg::ST_MISS);
  assign is_full      = done && (status == dwht_pkg::ST_FULL);

  `DWHT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "command taken but not busy")
  `DWHT_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
  `DWHT_ASSERT_SAME(a_status_code, done, status <= dwht_pkg::ST_FULL, "undefined status code")
  `DWHT_ASSERT_SAME(a_miss_zero, is_miss, payload_zero, "miss with non-zero payload")
  `DWHT_ASSERT_SAME(a_full_zero, is_full, payload_zero, "bucket full with non-zero payload")

endmodule

bind digit_weighted_hash_table dwht_checker u_dwht_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .status       (status),
  .result_key   (result_key),
  .result_value (result_value)
);

`default_nettype wire

// ----- bench/tb_digit_weighted_hash_table.sv -----
// ----------------------------------------------------------------------------
// tb_digit_weighted_hash_table
// Drives insert and search commands into the hash table in random bursts and
// checks every result against a behavioural copy of the table. The digit
// weights are reloaded between phases, with all-zero, all-six and all-seven
// settings among them.
// ----------------------------------------------------------------------------
module tb_digit_weighted_hash_table;
  timeunit 1ns;
  timeprecision 1ps;

  import dwht_pkg::*;

  localparam int NUM_BUCKETS = BUCKETS_DEF;
  localparam int BUCKET_SLOTS = SLOTS_PER_BUCKET_DEF;
  localparam int NUM_SLOTS = NUM_BUCKETS * BUCKET_SLOTS;
  localparam int PHASE_ITEMS = 140;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    key;
    logic [VALUE_W-1:0]  value;
  } outcome_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 opcode = OP_INSERT;
  logic [KEY_W-1:0]     key = '0;
  logic [VALUE_W-1:0]   value = '0;
  logic                 done;
  logic [STATUS_W-1:0]  status;
  logic [KEY_W-1:0]     result_key;
  logic [VALUE_W-1:0]   result_value;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WEIGHT_W-1:0]  cfg_data = '0;

  // table model
  weights_t           digit_weight = {WEIGHT_COUNT{3'd1}};
  logic [KEY_W-1:0]   stored_key [NUM_SLOTS];
  logic [VALUE_W-1:0] stored_value [NUM_SLOTS];
  logic               stored_used [NUM_SLOTS] = '{default: 1'b0};

  item_t              pending_items [$];
  outcome_t           expected_results [$];
  logic [KEY_W-1:0]   known_keys [$];
  int                 items_queued = 0;
  int                 results_seen = 0;
  int                 fault_count = 0;
  int                 burst_left = 1;
  int                 gap_left = 0;

  digit_weighted_hash_table uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .key          (key),
    .value        (value),
    .done         (done),
    .status       (status),
    .result_key   (result_key),
    .result_value (result_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int digit_bucket(logic [KEY_W-1:0] k);
    int rest;
    int sum;
    rest = int'(k);
    sum = 0;
    for (int p = 0; p < WEIGHT_COUNT; p++) begin
      sum += int'(digit_weight[p]) * (rest % 10);
      rest /= 10;
    end
    return sum % NUM_BUCKETS;
  endfunction

  function automatic outcome_t apply_command(item_t cmd);
    outcome_t res;
    int base;
    int hit;
    int free_slot;
    base = digit_bucket(cmd.key) * BUCKET_SLOTS;
    hit = -1;
    free_slot = -1;
    res = '{status: ST_OK, key: '0, value: '0};
    for (int s = base; s < base + BUCKET_SLOTS; s++) begin
      if (stored_used[s]) begin
        if (hit < 0 && stored_key[s] == cmd.key) hit = s;
      end else if (free_slot < 0) begin
        free_slot = s;
      end
    end
    if (cmd.opcode == OP_SEARCH) begin
      if (hit >= 0) begin
        res.key = stored_key[hit];
        res.value = stored_value[hit];
      end else begin
        res.status = ST_MISS;
      end
    end else if (hit >= 0) begin
      stored_value[hit] = cmd.value;
      res.key = cmd.key;
      res.value = cmd.value;
    end else if (free_slot >= 0) begin
      stored_key[free_slot] = cmd.key;
      stored_value[free_slot] = cmd.value;
      stored_used[free_slot] = 1'b1;
      res.key = cmd.key;
      res.value = cmd.value;
    end else begin
      res.status = ST_FULL;
    end
    return res;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45 && known_keys.size() > 0)
      return known_keys[$urandom_range(0, known_keys.size() - 1)];
    if (roll < 65) return KEY_W'($urandom_range(0, 999));
    if (roll < 88) return KEY_W'($urandom_range(0, 9999999));
    return KEY_W'($urandom_range(10000000, 24'hFFFFFF));
  endfunction

  task automatic queue_item(logic op, logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v);
    pending_items = {pending_items, item_t'({op, k, v})};
    items_queued++;
    if (op == OP_INSERT) known_keys = {known_keys, k};
  endtask

  task automatic queue_random(int count);
    for (int n = 0; n < count; n++)
      queue_item(logic'($urandom_range(0, 1)), pick_key(), $urandom);
  endtask

  task automatic wait_drained();
    while (results_seen < items_queued) @(posedge clk);
  endtask

  // caller is at a rising edge; cfg_valid is left high for back-to-back writes
  task automatic write_weight(logic [CFG_IDX_W-1:0] idx, logic [WEIGHT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx < WEIGHT_COUNT) digit_weight[idx] = data;
  endtask

  task automatic load_weights(weights_t w);
    for (int i = 0; i < WEIGHT_COUNT; i++) write_weight(CFG_IDX_W'(i), w[i]);
    // index past the last weight: must be ignored
    write_weight(CFG_IDX_W'(WEIGHT_COUNT), WEIGHT_W'($urandom_range(0, 7)));
    cfg_valid <= 1'b0;
  endtask

  // command driver
  always @(posedge clk) begin
    item_t cmd;
    outcome_t predicted;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predicted = apply_command({opcode, key, value});
        expected_results = {expected_results, predicted};
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cmd = pending_items.pop_front();
          start <= 1'b1;
          opcode <= cmd.opcode;
          key <= cmd.key;
          value <= cmd.value;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && done) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected transaction: status %0d key %0d value %h",
               status, result_key, result_value);
        fault_count++;
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          fault_count++;
        end
        if (result_key !== want.key) begin
          $error("result_key: expected %0d, actual %0d", want.key, result_key);
          fault_count++;
        end
        if (result_value !== want.value) begin
          $error("result_value: expected %h, actual %h", want.value, result_value);
          fault_count++;
        end
      end
    end
  end

  initial begin
    weights_t w;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // default weights: each digit counts once
    queue_item(OP_SEARCH, 24'd0, 32'h1234_5678);
    queue_item(OP_INSERT, 24'd0, 32'h0000_0000);
    queue_item(OP_SEARCH, 24'd0, 32'hFFFF_FFFF);
    queue_item(OP_INSERT, 24'd9999999, 32'hFFFF_FFFF);
    queue_item(OP_SEARCH, 24'd9999999, 32'h0);
    queue_item(OP_INSERT, 24'hFFFFFF, 32'h8000_0001);
    queue_item(OP_SEARCH, 24'hFFFFFF, 32'h0);
    queue_item(OP_SEARCH, 24'd6777215, 32'h0);
    queue_item(OP_INSERT, 24'd0, 32'hA5A5_A5A5);
    // fill one bucket (digit sum 3 mod 7), then overflow it
    queue_item(OP_INSERT, 24'd3, 32'h0000_0003);
    queue_item(OP_INSERT, 24'd12, 32'h0000_0012);
    queue_item(OP_INSERT, 24'd21, 32'h0000_0021);
    queue_item(OP_INSERT, 24'd30, 32'h0000_0030);
    queue_item(OP_INSERT, 24'd102, 32'h0000_0102);
    queue_item(OP_INSERT, 24'd111, 32'h0000_0111);
    queue_item(OP_INSERT, 24'd120, 32'h0000_0120);
    queue_item(OP_INSERT, 24'd201, 32'h0000_0201);
    queue_item(OP_INSERT, 24'd210, 32'h0000_0210);
    queue_item(OP_SEARCH, 24'd210, 32'h0);
    queue_item(OP_INSERT, 24'd3, 32'h5A5A_5A5A);
    queue_item(OP_SEARCH, 24'd201, 32'h0);
    queue_item(OP_SEARCH, 24'd10000000, 32'h0);
    queue_random(PHASE_ITEMS);

    for (int phase = 0; phase < 7; phase++) begin
      wait_drained();
      case (phase)
        0: w = {WEIGHT_COUNT{3'd7}};
        1: w = {WEIGHT_COUNT{3'd0}};
        2: w = {WEIGHT_COUNT{3'd6}};
        default: begin
          for (int i = 0; i < WEIGHT_COUNT; i++) w[i] = WEIGHT_W'($urandom_range(0, 7));
        end
      endcase
      load_weights(w);
      queue_random(PHASE_ITEMS);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d transactions still outstanding", expected_results.size());
      fault_count++;
    end
    if (fault_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- digit_weighted_hash_table.f -----
+incdir+hw/rtl
hw/rtl/dwht_pkg.sv
hw/rtl/dwht_queue.sv
hw/rtl/dwht_front.sv
hw/rtl/dwht_back.sv
hw/rtl/digit_weighted_hash_table.sv
hw/rtl/dwht_checker.sv
bench/tb_digit_weighted_hash_table.sv
